FILE: rtl/bml_pkg.sv
package bml_pkg;

    localparam int NUM_COMPONENTS = 8;
    localparam int NUM_FEATURES   = 64;
    localparam int NUM_CATEGORIES = 32;

    localparam int COMP_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam int FEAT_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int CAT_W  = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

    localparam int WDEPTH = NUM_CATEGORIES * NUM_COMPONENTS;
    localparam int PDEPTH = NUM_COMPONENTS * NUM_FEATURES;
    localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int PADDR_W = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

    localparam logic [1:0] OP_WR_WEIGHT = 2'd0;
    localparam logic [1:0] OP_WR_PROB   = 2'd1;
    localparam logic [1:0] OP_SCORE     = 2'd2;

    localparam logic [11:0] EXP_MAX = 12'hFFF;
    localparam logic [16:0] Q_ONE   = 17'h10000;

    typedef struct packed {
        logic [31:0] m;
        logic [11:0] e;
    } num_t;

    // controller -> datapath
    typedef struct packed {
        logic             wr_weight;
        logic             wr_prob;
        logic [WADDR_W-1:0] waddr;
        logic [PADDR_W-1:0] paddr;
        logic [16:0]      wdata;
        logic             rd_weight;
        logic             rd_prob;
        logic [WADDR_W-1:0] rd_waddr;
        logic [PADDR_W-1:0] rd_paddr;
        logic             load_q;      // q <- registered weight
        logic             mul_step;    // q <- q * factor(registered theta)
        logic             add_step;    // total <- total + q
        logic             clr_total;
        logic             feat_bit;    // sample bit matching the theta in flight
    } dp_cmd_t;

    function automatic num_t num_zero();
        num_t z;
        z.m = '0;
        z.e = EXP_MAX;
        return z;
    endfunction

    function automatic num_t num_from_q16(input logic [16:0] v);
        num_t r;
        int p;
        p = 0;
        for (int i = 1; i <= 16; i++) begin
            if (v[i]) p = i;
        end
        if (v == '0) begin
            r = num_zero();
        end else begin
            r.m = 32'(v) << (31 - p);
            r.e = 12'(16 - p);
        end
        return r;
    endfunction

endpackage

FILE: rtl/bernoulli_mixture_likelihood.sv
// Bernoulli mixture likelihood scorer.
// Slave channel s_*: one transfer is a table write or a score request.
//   op 0 writes a category weight, op 1 a component feature probability;
//   these give no result. op 2 scores a sample.
// Master channel m_*: one transfer per score: mantissa, exponent, popcount.
// Scoring walks each component: one weight read, then one multiply per
// feature through a single shared multiplier, then one add. m_tvalid rises
// after the add of the last component; scoring speed is set by the one
// multiplier and the single read port of the theta memory.
// One item is in work at a time; s_tready is high only when idle.
// A score with category out of range skips the datapath and gives zero.
// Reset (aresetn low, synchronous) returns the controller to idle;
// table contents are undefined until written.
// When the receiver stalls, the result holds on m_tdata and no new item
// is taken until it is transferred.
module bernoulli_mixture_likelihood
    import bml_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[1:0], category[6:2], component[12:7], feature_index[18:13],
    // prob_value[35:19], features[99:36], zero pad to 104
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // likelihood_mantissa[31:0], likelihood_exponent[43:32],
    // set_bit_count[50:44], zero pad to 56
    output logic [55:0]  m_tdata
);

    dp_cmd_t     cmd;
    num_t        total;
    logic [6:0]  count;
    logic        zero_res;

    bml_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .op            (s_tdata[1:0]),
        .category      (s_tdata[6:2]),
        .component     (s_tdata[12:7]),
        .feature_index (s_tdata[18:13]),
        .prob_value    (s_tdata[35:19]),
        .features      (s_tdata[99:36]),
        .cmd           (cmd),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res_count     (count),
        .res_zero      (zero_res)
    );

    bml_datapath u_dp (
        .aclk  (aclk),
        .cmd   (cmd),
        .total (total)
    );

    // out-of-range category skips the datapath; total was cleared anyway
    assign m_tdata = {5'd0, count, (zero_res ? EXP_MAX : total.e),
                      (zero_res ? 32'd0 : total.m)};

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.mul_step && cmd.add_step))
        else $error("multiply and add in one cycle");

endmodule

FILE: rtl/bml_ctrl.sv
module bml_ctrl
    import bml_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [4:0]        category,
    input  logic [5:0]        component,
    input  logic [5:0]        feature_index,
    input  logic [16:0]       prob_value,
    input  logic [63:0]       features,
    output dp_cmd_t           cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [6:0]        res_count,
    output logic              res_zero
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDW  = 3'd1;
    localparam logic [2:0] S_LDQ  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [COMP_W-1:0] comp_reg, comp_next;
    logic [FEAT_W:0]   feat_reg, feat_next;   // feature of theta now being read
    logic [FEAT_W-1:0] mfeat_reg, mfeat_next; // feature whose theta is registered
    logic [CAT_W-1:0]  cat_reg;
    logic [63:0]       bits_reg;
    logic [6:0]        count_reg;
    logic              zero_reg;
    logic              accept;
    logic [6:0]        pop;
    logic              last_comp;

    always_comb begin
        pop = '0;
        for (int i = 0; i < NUM_FEATURES; i++) pop = pop + 7'(features[i]);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == S_OUT);
    assign res_count = count_reg;
    assign res_zero  = zero_reg;
    assign last_comp = (32'(comp_reg) == NUM_COMPONENTS - 1);

    always_comb begin
        state_next = state_reg;
        comp_next  = comp_reg;
        feat_next  = feat_reg;
        mfeat_next = mfeat_reg;
        cmd = '0;
        cmd.waddr = WADDR_W'(32'(category) * NUM_COMPONENTS + 32'(component));
        cmd.paddr = PADDR_W'(32'(component) * NUM_FEATURES + 32'(feature_index));
        cmd.wdata = prob_value;
        cmd.rd_waddr = WADDR_W'(32'(cat_reg) * NUM_COMPONENTS + 32'(comp_reg));
        cmd.rd_paddr = PADDR_W'(32'(comp_reg) * NUM_FEATURES
                       + 32'(feat_reg[FEAT_W-1:0]));
        cmd.feat_bit = bits_reg[mfeat_reg];
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.wr_weight = (op == OP_WR_WEIGHT)
                        && (32'(category) < NUM_CATEGORIES)
                        && (32'(component) < NUM_COMPONENTS);
                    cmd.wr_prob = (op == OP_WR_PROB)
                        && (32'(component) < NUM_COMPONENTS)
                        && (32'(feature_index) < NUM_FEATURES);
                    if (op == OP_SCORE) begin
                        cmd.clr_total = 1'b1;
                        comp_next = '0;
                        state_next = (32'(category) < NUM_CATEGORIES) ? S_RDW : S_OUT;
                    end
                end
            end
            S_RDW: begin
                cmd.rd_weight = 1'b1;
                feat_next = '0;
                state_next = S_LDQ;
            end
            S_LDQ: begin
                cmd.load_q = 1'b1;
                cmd.rd_prob = 1'b1;
                mfeat_next = '0;
                feat_next = (FEAT_W+1)'(1);
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                mfeat_next = feat_reg[FEAT_W-1:0];
                if (32'(feat_reg) < NUM_FEATURES) begin
                    cmd.rd_prob = 1'b1;
                    feat_next = feat_reg + 1'b1;
                end else begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                cmd.add_step = 1'b1;
                if (last_comp) begin
                    state_next = S_OUT;
                end else begin
                    comp_next = comp_reg + 1'b1;
                    state_next = S_RDW;
                end
            end
            S_OUT: begin
                if (res_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        comp_reg  <= comp_next;
        feat_reg  <= feat_next;
        mfeat_reg <= mfeat_next;
        if (accept) begin
            cat_reg   <= CAT_W'(category);
            bits_reg  <= features;
            count_reg <= pop;
            zero_reg  <= !(32'(category) < NUM_CATEGORIES);
        end
    end

endmodule

FILE: rtl/bml_datapath.sv
module bml_datapath
    import bml_pkg::*;
(
    input  logic        aclk,
    input  dp_cmd_t     cmd,
    output num_t        total
);

    logic [16:0] wmem [WDEPTH];
    logic [16:0] pmem [PDEPTH];
    logic [16:0] wq_reg;
    logic [16:0] th_reg;
    num_t        q_reg, total_reg;
    num_t        fnum, mul_r, add_r, big, sml;
    logic [16:0] fval;
    logic [63:0] prod;
    logic [12:0] s;
    logic [11:0] d;
    logic [32:0] sum;

    always_ff @(posedge aclk) begin
        if (cmd.wr_weight) wmem[cmd.waddr] <= cmd.wdata;
        if (cmd.wr_prob) pmem[cmd.paddr] <= cmd.wdata;
        if (cmd.rd_weight) wq_reg <= wmem[cmd.rd_waddr];
        if (cmd.rd_prob) th_reg <= pmem[cmd.rd_paddr];
    end

    always_comb begin
        if (cmd.feat_bit) fval = th_reg;
        else fval = (th_reg >= Q_ONE) ? 17'd0 : Q_ONE - th_reg;
        fnum = num_from_q16(fval);
        prod = 64'(q_reg.m) * 64'(fnum.m);
        s = 13'(q_reg.e) + 13'(fnum.e);
        mul_r = num_zero();
        if (q_reg.m != '0 && fnum.m != '0) begin
            if (prod[63]) begin
                if (s == '0) begin
                    mul_r.m = '1;
                    mul_r.e = '0;
                end else if (s - 13'd1 <= 13'(EXP_MAX)) begin
                    mul_r.m = prod[63:32];
                    mul_r.e = 12'(s - 13'd1);
                end
            end else if (s <= 13'(EXP_MAX)) begin
                mul_r.m = prod[62:31];
                mul_r.e = s[11:0];
            end
        end
    end

    always_comb begin
        if (total_reg.e <= q_reg.e) begin
            big = total_reg;
            sml = q_reg;
        end else begin
            big = q_reg;
            sml = total_reg;
        end
        d = sml.e - big.e;
        sum = 33'(big.m) + ((d >= 12'd32) ? 33'd0 : 33'(sml.m >> d[4:0]));
        if (total_reg.m == '0) begin
            add_r = q_reg;
        end else if (q_reg.m == '0) begin
            add_r = total_reg;
        end else if (sum[32]) begin
            if (big.e == '0) begin
                add_r.m = '1;
                add_r.e = '0;
            end else begin
                add_r.m = sum[32:1];
                add_r.e = big.e - 12'd1;
            end
        end else begin
            add_r.m = sum[31:0];
            add_r.e = big.e;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_q) q_reg <= num_from_q16(wq_reg);
        else if (cmd.mul_step) q_reg <= mul_r;
        if (cmd.clr_total) total_reg <= num_zero();
        else if (cmd.add_step) total_reg <= add_r;
    end

    assign total = total_reg;

endmodule
